// ----- design/tltc_pkg.sv -----
// shared types, constants and a helper function for the tap tempo lfo rate control
// no dependencies; imported by every module of the block
`default_nettype none

package tltc_pkg;

    // mode codes
    typedef enum logic [1:0] {
        MODE_POT   = 2'd0,
        MODE_TAP   = 2'd1,
        MODE_SWELL = 2'd2
    } t_mode;

    // configuration register indexes
    localparam logic [1:0] CFG_SWELL_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_POT_FLOOR       = 2'd1;
    localparam logic [1:0] CFG_ADC_FULL_SCALE  = 2'd2;
    localparam logic [1:0] CFG_SWELL_PERIOD    = 2'd3;

    // subdivision select codes
    localparam logic [1:0] SUB_X1      = 2'd0;
    localparam logic [1:0] SUB_HALF    = 2'd1;
    localparam logic [1:0] SUB_3_4     = 2'd2;
    localparam logic [1:0] SUB_QUARTER = 2'd3;

    localparam int          WAVE_STEP  = 205;
    localparam logic [15:0] SWELL_STEP = 16'd1;

    localparam logic [31:0] RST_SWELL_THRESHOLD = 32'd65535;
    localparam logic [9:0]  RST_POT_FLOOR       = 10'd0;
    localparam logic [9:0]  RST_ADC_FULL_SCALE  = 10'd1023;
    localparam logic [6:0]  RST_SWELL_PERIOD    = 7'd100;

    typedef struct packed {
        logic [9:0]  rate_pot;
        logic [9:0]  subdivision_pot;
        logic [9:0]  wave_pot;
        logic [31:0] tap_count;
        logic        button_held;
        logic        tap_pressed;
    } t_in_item;

    typedef struct packed {
        logic [15:0] rate_word;
        logic [2:0]  wave_sel;
        logic [1:0]  rate_mode;
    } t_result;

    typedef struct packed {
        logic [31:0] swell_threshold;
        logic [9:0]  pot_floor;
        logic [9:0]  adc_full_scale;
        logic [6:0]  swell_period;
    } t_cfg;

    typedef struct packed {
        t_mode       current_mode;
        t_mode       previous_mode;
        logic        tap_pending;
        logic [6:0]  loop_counter;
        logic [15:0] rate_register;
    } t_state;

    // wave pot over 205, pot never exceeds 1023 so the quotient is 0..4
    function automatic logic [2:0] wave_index(input logic [9:0] pot);
        logic [2:0] q;
        if (pot >= 10'(4 * WAVE_STEP)) begin
            q = 3'd4;
        end else if (pot >= 10'(3 * WAVE_STEP)) begin
            q = 3'd3;
        end else if (pot >= 10'(2 * WAVE_STEP)) begin
            q = 3'd2;
        end else if (pot >= 10'(WAVE_STEP)) begin
            q = 3'd1;
        end else begin
            q = 3'd0;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- design/tltc_in_if.sv -----
// input channel of the rate control block: valid/ready plus one control sample
// no dependencies
`default_nettype none

interface tltc_in_if;
    logic        valid;
    logic        ready;
    logic [9:0]  rate_pot;
    logic [9:0]  subdivision_pot;
    logic [9:0]  wave_pot;
    logic [31:0] tap_count;
    logic        button_held;
    logic        tap_pressed;

    modport source (
        output valid, rate_pot, subdivision_pot, wave_pot, tap_count,
               button_held, tap_pressed,
        input  ready
    );
    modport sink (
        input  valid, rate_pot, subdivision_pot, wave_pot, tap_count,
               button_held, tap_pressed,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/tltc_out_if.sv -----
// result channel of the rate control block: valid/ready plus rate, wave and mode
// no dependencies
`default_nettype none

interface tltc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rate_word;
    logic [2:0]  wave_sel;
    logic [1:0]  rate_mode;

    modport source (
        output valid, rate_word, wave_sel, rate_mode,
        input  ready
    );
    modport sink (
        input  valid, rate_word, wave_sel, rate_mode,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/tap_tempo_lfo_rate_control.sv -----
// tap tempo lfo rate control, top level
// a result is registered as its item moves on; the input and result registers form
// a two stage pipe with one item per cycle unless o_out.ready stalls it, and the
// mode/rate state updates as an item moves into the result register
// reset (synchronous, active low): config defaults, pot mode, pending, counter
// and rate word cleared, both stages empty
`default_nettype none

module tap_tempo_lfo_rate_control
    import tltc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tltc_in_if.sink          i_in,
    tltc_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    t_cfg     cfg;
    t_in_item in_item;
    t_in_item r_item;
    logic     r_item_valid;
    t_state   r_state;
    t_state   n_state;
    t_result  n_result;
    t_result  r_result;
    logic     r_out_valid;
    logic     advance;
    logic     in_take;

    // config bank
    tltc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // pack the incoming sample
    assign in_item.rate_pot        = i_in.rate_pot;
    assign in_item.subdivision_pot = i_in.subdivision_pot;
    assign in_item.wave_pot        = i_in.wave_pot;
    assign in_item.tap_count       = i_in.tap_count;
    assign in_item.button_held     = i_in.button_held;
    assign in_item.tap_pressed     = i_in.tap_pressed;

    // the held item moves on when the result slot is free or being drained
    assign advance   = r_item_valid && (!r_out_valid || o_out.ready);
    // input slot can take a new item when empty or emptying this cycle
    assign i_in.ready = !r_item_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    // per-sample computation against the live state
    tltc_calc u_calc (
        .i_item   (r_item),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (in_take) begin
            r_item_valid <= 1'b1;
        end else if (advance) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= in_item;
        end
    end

    // loop state: only committed when an item reaches the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.current_mode  <= MODE_POT;
            r_state.previous_mode <= MODE_POT;
            r_state.tap_pending   <= 1'b0;
            r_state.loop_counter  <= 7'd0;
            r_state.rate_register <= 16'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.rate_word = r_result.rate_word;
    assign o_out.wave_sel  = r_result.wave_sel;
    assign o_out.rate_mode = r_result.rate_mode;

endmodule

`default_nettype wire

// ----- design/tltc_cfg.sv -----
// configuration register bank of the rate control block
// depends on tltc_pkg
`default_nettype none

module tltc_cfg
    import tltc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_we,
    input  wire logic [1:0]  i_idx,
    input  wire logic [31:0] i_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swell_threshold <= RST_SWELL_THRESHOLD;
            r_cfg.pot_floor       <= RST_POT_FLOOR;
            r_cfg.adc_full_scale  <= RST_ADC_FULL_SCALE;
            r_cfg.swell_period    <= RST_SWELL_PERIOD;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_SWELL_THRESHOLD: r_cfg.swell_threshold <= i_data;
                CFG_POT_FLOOR:       r_cfg.pot_floor       <= i_data[9:0];
                CFG_ADC_FULL_SCALE:  r_cfg.adc_full_scale  <= i_data[9:0];
                CFG_SWELL_PERIOD:    r_cfg.swell_period    <= i_data[6:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- design/tltc_calc.sv -----
// per-sample logic: mode choice, raw rate, quantize and subdivision scaling
// depends on tltc_pkg
`default_nettype none

module tltc_calc
    import tltc_pkg::*;
(
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    input  t_state   i_state,
    output t_state   o_state,
    output t_result  o_result
);

    logic        pending;
    logic        want_change;
    t_mode       target;
    t_mode       cur;
    t_mode       prev;
    logic [15:0] raw;
    logic [15:0] quant;
    logic [15:0] scaled;
    logic [15:0] pot_rev;
    logic [16:0] times3;
    logic [7:0]  lc_inc;
    logic        dec_due;

    // mode choice in priority order
    always_comb begin
        pending     = i_state.tap_pending | i_item.tap_pressed;
        want_change = 1'b0;
        target      = i_state.current_mode;
        if (i_item.button_held && (i_item.tap_count >= i_cfg.swell_threshold)) begin
            pending     = 1'b0;
            want_change = 1'b1;
            target      = MODE_SWELL;
        end else if (!i_item.button_held && (i_state.current_mode == MODE_SWELL)) begin
            pending     = 1'b0;
            want_change = 1'b1;
            target      = i_state.previous_mode;
        end else if (!i_item.button_held && pending) begin
            pending     = 1'b0;
            want_change = 1'b1;
            target      = MODE_TAP;
        end else if (i_item.rate_pot == i_cfg.pot_floor) begin
            want_change = 1'b1;
            target      = MODE_POT;
        end

        cur  = i_state.current_mode;
        prev = i_state.previous_mode;
        if (want_change && (target != i_state.current_mode)) begin
            prev = i_state.current_mode;
            cur  = target;
        end
    end

    assign lc_inc  = {1'b0, i_state.loop_counter} + 8'd1;
    assign dec_due = (lc_inc >= {1'b0, i_cfg.swell_period})
                     && (i_state.rate_register > {6'd0, i_cfg.pot_floor});
    assign pot_rev = {6'd0, i_cfg.adc_full_scale} + {6'd0, i_cfg.pot_floor}
                     - {6'd0, i_item.rate_pot};

    always_comb begin
        case (cur)
            MODE_TAP:   raw = i_item.tap_count[17:2];
            MODE_SWELL: raw = dec_due ? (i_state.rate_register - SWELL_STEP)
                                      : i_state.rate_register;
            MODE_POT:   raw = {1'b0, pot_rev[15:1]};
            default:    raw = i_state.rate_register;
        endcase
    end

    assign quant  = {raw[15:2], 2'b00};
    assign times3 = {1'b0, quant} + {quant, 1'b0};

    always_comb begin
        case (i_item.subdivision_pot[9:8])
            SUB_HALF:    scaled = {1'b0, quant[15:1]};
            SUB_3_4:     scaled = {2'b00, times3[15:2]};
            SUB_QUARTER: scaled = {2'b00, quant[15:2]};
            default:     scaled = quant;
        endcase
    end

    always_comb begin
        o_state.current_mode  = cur;
        o_state.previous_mode = prev;
        o_state.tap_pending   = pending;
        o_state.rate_register = scaled;
        o_state.loop_counter  = (lc_inc > {1'b0, i_cfg.swell_period}) ? 7'd0
                                                                       : lc_inc[6:0];
    end

    assign o_result.rate_word = scaled;
    assign o_result.wave_sel  = wave_index(i_item.wave_pot);
    assign o_result.rate_mode = cur;

endmodule

`default_nettype wire
